### hw/rtl/queens_local_search_step_macros.svh
// ----------------------------------------------------------------------------
// queens_local_search_step assertion macros
// Shorthand for the clocked, reset-gated properties of the port checker.
// ----------------------------------------------------------------------------
`ifndef QUEENS_LOCAL_SEARCH_STEP_MACROS_SVH
`define QUEENS_LOCAL_SEARCH_STEP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define QLS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define QLS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/qls_pkg.sv
// ----------------------------------------------------------------------------
// qls_pkg
// Shared widths, codes, state types and control structs of the queens step.
// ----------------------------------------------------------------------------
package qls_pkg;

  localparam int QUEENS_DEF = 8;

  localparam int CMD_W  = 1;
  localparam int COL_W  = 3;
  localparam int AMT_W  = 3;
  localparam int PCT_W  = 7;
  localparam int COST_W = 5;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [PCT_W-1:0]  ACCEPT_RESET = 7'd30;
  localparam logic [COST_W-1:0] COST_MAX     = 5'd31;

  // register index taken from paddr above the byte offset
  localparam logic [CFG_ADDR_W-3:0] CFG_IDX_ACCEPT = 1'b0;

  localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
  localparam logic [CMD_W-1:0] CMD_MOVE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_ROWA,
    S_PAIR,
    S_EVAL,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_PLAIN,
    PH_BEFORE,
    PH_AFTER
  } phase_t;

  typedef struct packed {
    logic capture;
    logic rd_col;
    logic save_old;
    logic write_load;
    logic start_count;
    logic row_a;
    logic pair;
    logic latch_before;
    logic finish_move;
    logic finish_plain;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic col_ok;
    logic item_move;
    logic row_end;
    logic last_pair;
    logic out_free;
  } dp_stat_t;

endpackage

### hw/rtl/qls_in_if.sv
// ----------------------------------------------------------------------------
// qls_in_if
// Input item channel: load or move command with valid/ready handshake.
// ----------------------------------------------------------------------------
interface qls_in_if;
  import qls_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [COL_W-1:0] column;
  logic [AMT_W-1:0] amount;
  logic [PCT_W-1:0] chance;

  modport source (output valid, command, column, amount, chance, input ready);
  modport sink   (input valid, command, column, amount, chance, output ready);
endinterface

### hw/rtl/qls_out_if.sv
// ----------------------------------------------------------------------------
// qls_out_if
// Result item channel: board cost and move-kept flag with valid/ready.
// ----------------------------------------------------------------------------
interface qls_out_if;
  import qls_pkg::*;

  logic              valid;
  logic              ready;
  logic [COST_W-1:0] cost;
  logic              accepted;

  modport source (output valid, cost, accepted, input ready);
  modport sink   (input valid, cost, accepted, output ready);
endinterface

### hw/rtl/qls_regs.sv
// ----------------------------------------------------------------------------
// qls_regs
// APB-style configuration register file holding the accept threshold.
// ----------------------------------------------------------------------------
module qls_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qls_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [qls_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [qls_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [qls_pkg::PCT_W-1:0]      accept_percent
);
  import qls_pkg::*;

  logic [PCT_W-1:0] accept_r;
  logic [PCT_W-1:0] accept_nxt;
  logic             hit_accept;

  assign hit_accept = (paddr[CFG_ADDR_W-1:2] == CFG_IDX_ACCEPT);
  assign pready     = 1'b1;

  always_comb begin
    accept_nxt = accept_r;
    if (psel && penable && pwrite && hit_accept) begin
      accept_nxt = pwdata[PCT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accept_r <= ACCEPT_RESET;
    end else begin
      accept_r <= accept_nxt;
    end
  end

  assign prdata         = hit_accept ? CFG_DATA_W'(accept_r) : '0;
  assign accept_percent = accept_r;
endmodule

### hw/rtl/qls_ctrl.sv
// ----------------------------------------------------------------------------
// qls_ctrl
// Sequencer: walks the pair scan before and after a move and hands off result.
// ----------------------------------------------------------------------------
module qls_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  qls_pkg::dp_stat_t  stat,
  output qls_pkg::ctrl_cmd_t cmd
);
  import qls_pkg::*;

  state_t state_r;
  state_t state_nxt;
  phase_t phase_r;
  phase_t phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_PLAIN;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.rd_col      = 1'b1;
        cmd.start_count = 1'b1;
        if (stat.col_ok && stat.item_move) begin
          cmd.save_old = 1'b1;
          phase_nxt    = PH_BEFORE;
        end else begin
          // off-board column leaves the board alone
          cmd.write_load = stat.col_ok;
          phase_nxt      = PH_PLAIN;
        end
        state_nxt = S_ROWA;
      end
      S_ROWA: begin
        cmd.row_a = 1'b1;
        state_nxt = S_PAIR;
      end
      S_PAIR: begin
        cmd.pair = 1'b1;
        if (stat.last_pair) begin
          state_nxt = S_EVAL;
        end else if (stat.row_end) begin
          state_nxt = S_ROWA;
        end
      end
      S_EVAL: begin
        case (phase_r)
          PH_BEFORE: begin
            cmd.latch_before = 1'b1;
            cmd.start_count  = 1'b1;
            phase_nxt        = PH_AFTER;
            state_nxt        = S_ROWA;
          end
          PH_AFTER: begin
            cmd.finish_move = 1'b1;
            state_nxt       = S_OUT;
          end
          default: begin
            cmd.finish_plain = 1'b1;
            state_nxt        = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule

### hw/rtl/qls_dp.sv
// ----------------------------------------------------------------------------
// qls_dp
// Board registers, one-pair-per-cycle attack counter and result register.
// ----------------------------------------------------------------------------
module qls_dp #(
  parameter int QUEENS = qls_pkg::QUEENS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  qls_pkg::ctrl_cmd_t         cmd,
  output qls_pkg::dp_stat_t          stat,
  input  logic [qls_pkg::CMD_W-1:0]  in_command,
  input  logic [qls_pkg::COL_W-1:0]  in_column,
  input  logic [qls_pkg::AMT_W-1:0]  in_amount,
  input  logic [qls_pkg::PCT_W-1:0]  in_chance,
  input  logic [qls_pkg::PCT_W-1:0]  accept_percent,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [qls_pkg::COST_W-1:0] out_cost,
  output logic                       out_accepted
);
  import qls_pkg::*;

  localparam int IDX_W    = $clog2(QUEENS);
  localparam int PAIR_MAX = QUEENS * (QUEENS - 1) / 2;
  localparam int CNT_W    = $clog2(PAIR_MAX + 1);
  localparam int CMP_W    = ((IDX_W > COL_W) ? IDX_W : COL_W) + 1;
  localparam int SAT_W    = (CNT_W > COST_W) ? CNT_W : COST_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEENS - 1);
  localparam logic [IDX_W-1:0] LAST_A   = IDX_W'(QUEENS - 2);

  // item registers
  logic [CMD_W-1:0]  cmd_r;
  logic [IDX_W-1:0]  col_r;
  logic              col_ok_r;
  logic [IDX_W-1:0]  amt_r;
  logic [PCT_W-1:0]  chance_r;

  // board and scan state
  logic [IDX_W-1:0]  board_r   [QUEENS];
  logic [IDX_W-1:0]  board_nxt [QUEENS];
  logic [IDX_W-1:0]  old_row_r;
  logic [IDX_W-1:0]  a_r;
  logic [IDX_W-1:0]  b_r;
  logic [IDX_W-1:0]  ra_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  before_r;
  logic [COST_W-1:0] res_cost_r;
  logic              res_kept_r;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [COST_W-1:0] out_cost_r;
  logic              out_kept_r;

  logic [CMP_W-1:0]  amt_ext;
  logic [CMP_W-1:0]  amt_red;
  logic              col_ok;
  logic [IDX_W:0]    sum_row;
  logic [IDX_W-1:0]  new_row;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  rd_row;
  logic [IDX_W-1:0]  gap;
  logic [IDX_W-1:0]  col_span;
  logic              hit;
  logic              keep;
  logic [CNT_W-1:0]  cost_sel;
  logic [SAT_W-1:0]  cost_ext;
  logic [COST_W-1:0] cost_sat;

  // amount below 8 stays below twice the board size
  assign amt_ext = CMP_W'(in_amount);
  assign amt_red = (amt_ext >= CMP_W'(QUEENS)) ? amt_ext - CMP_W'(QUEENS) : amt_ext;
  assign col_ok  = (CMP_W'(in_column) < CMP_W'(QUEENS));

  assign sum_row = {1'b0, old_row_r} + {1'b0, amt_r};
  assign new_row = (sum_row >= (IDX_W + 1)'(QUEENS)) ?
                   IDX_W'(sum_row - (IDX_W + 1)'(QUEENS)) : IDX_W'(sum_row);

  // single read port on the board
  assign rd_idx = cmd.rd_col ? col_r : (cmd.row_a ? a_r : b_r);
  assign rd_row = board_r[rd_idx];

  assign gap      = (ra_r > rd_row) ? ra_r - rd_row : rd_row - ra_r;
  assign col_span = b_r - a_r;
  assign hit      = (gap == '0) || (gap == col_span);

  assign keep = (cnt_r < before_r) || (chance_r < accept_percent);

  always_comb begin
    cost_sel = cnt_r;
    if (cmd.finish_move && !keep) begin
      cost_sel = before_r;
    end
  end

  assign cost_ext = SAT_W'(cost_sel);
  assign cost_sat = (cost_ext > SAT_W'(COST_MAX)) ? COST_MAX : COST_W'(cost_ext);

  always_comb begin
    for (int i = 0; i < QUEENS; i++) begin
      board_nxt[i] = board_r[i];
      if (col_r == IDX_W'(i)) begin
        if (cmd.write_load) begin
          board_nxt[i] = amt_r;
        end else if (cmd.latch_before) begin
          board_nxt[i] = new_row;
        end else if (cmd.finish_move && !keep) begin
          board_nxt[i] = old_row_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUEENS; i++) begin
        board_r[i] <= IDX_W'(i);
      end
    end else begin
      for (int i = 0; i < QUEENS; i++) begin
        board_r[i] <= board_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r    <= in_command;
      col_r    <= IDX_W'(in_column);
      col_ok_r <= col_ok;
      amt_r    <= IDX_W'(amt_red);
      chance_r <= in_chance;
    end
    if (cmd.save_old) begin
      old_row_r <= rd_row;
    end
    if (cmd.start_count) begin
      a_r   <= '0;
      cnt_r <= '0;
    end
    if (cmd.row_a) begin
      ra_r <= rd_row;
      b_r  <= a_r + 1'b1;
    end
    if (cmd.pair) begin
      cnt_r <= cnt_r + CNT_W'(hit);
      if (b_r == LAST_IDX) begin
        a_r <= a_r + 1'b1;
      end else begin
        b_r <= b_r + 1'b1;
      end
    end
    if (cmd.latch_before) begin
      before_r <= cnt_r;
    end
    if (cmd.finish_move || cmd.finish_plain) begin
      res_cost_r <= cost_sat;
      res_kept_r <= cmd.finish_move && keep;
    end
    if (cmd.out_load) begin
      out_cost_r <= res_cost_r;
      out_kept_r <= res_kept_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign stat.col_ok    = col_ok_r;
  assign stat.item_move = (cmd_r == CMD_MOVE);
  assign stat.row_end   = (b_r == LAST_IDX);
  assign stat.last_pair = (b_r == LAST_IDX) && (a_r == LAST_A);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_cost     = out_cost_r;
  assign out_accepted = out_kept_r;
endmodule

### hw/rtl/queens_local_search_step.sv
// ----------------------------------------------------------------------------
// queens_local_search_step
// One step of stochastic hill climbing on an N-queens board.
// ----------------------------------------------------------------------------
// in_ch carries load items (command 0: set a column's row) and move items
// (command 1: add amount to a column's row modulo QUEENS). Each item yields
// one result on out_ch: the attacking-pair count after the item and whether
// the move was kept. A worse move is still kept when chance is below the
// accept_percent register, written through the cfg_ APB port at address 0.
// One item is worked on at a time. Cost is counted by a single comparator
// that visits one column pair per cycle, plus one row fetch per outer column.
// A move counts twice, before and after the change; a load or an off-board
// column counts once. The result register lets a new item enter while the
// previous result still waits; if out_ch stays stalled the next result holds
// the block, and in_ch.ready stays low, until the register frees.
// Reset puts queen i on row i and accept_percent at 30.
// ----------------------------------------------------------------------------
module queens_local_search_step #(
  parameter int QUEENS = qls_pkg::QUEENS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  qls_in_if.sink                         in_ch,
  qls_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [qls_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [qls_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [qls_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import qls_pkg::*;

  ctrl_cmd_t        cmd;
  dp_stat_t         stat;
  logic [PCT_W-1:0] accept_percent;

  qls_regs u_regs (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (cfg_psel),
    .penable        (cfg_penable),
    .pwrite         (cfg_pwrite),
    .paddr          (cfg_paddr),
    .pwdata         (cfg_pwdata),
    .prdata         (cfg_prdata),
    .pready         (cfg_pready),
    .accept_percent (accept_percent)
  );

  qls_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  qls_dp #(
    .QUEENS (QUEENS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_command     (in_ch.command),
    .in_column      (in_ch.column),
    .in_amount      (in_ch.amount),
    .in_chance      (in_ch.chance),
    .accept_percent (accept_percent),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_cost       (out_ch.cost),
    .out_accepted   (out_ch.accepted)
  );
endmodule

### hw/rtl/qls_checker.sv
// ----------------------------------------------------------------------------
// qls_checker
// Port-level checks of the queens step, bound to the top level.
// ----------------------------------------------------------------------------
`include "queens_local_search_step_macros.svh"

module qls_checker (
  input logic       clk,
  input logic       rst_n,
  qls_in_if.sink    in_ch,
  qls_out_if.source out_ch
);
  import qls_pkg::*;

  // a stalled result keeps its payload
  `QLS_ASSERT_NXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.cost) && $stable(out_ch.accepted), "stalled result changed")

  // one item at a time: input closes right after an accept
  `QLS_ASSERT_NXT(a_one_item, in_ch.valid && in_ch.ready, !in_ch.ready, "second item taken while busy")

  // handing a result over returns the block to idle
  `QLS_ASSERT_IMP(a_idle_after_result, $rose(out_ch.valid), in_ch.ready, "block not idle after result")
endmodule

bind queens_local_search_step qls_checker u_qls_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

### sim/queens_local_search_step_tb.sv
// ----------------------------------------------------------------------------
// queens_local_search_step_tb
// Drives load and move items into the queens step, writes the accept_percent
// register through the APB port between phases, and checks every result
// against a board-tracking predictor, with random gaps on both channels.
// ----------------------------------------------------------------------------
module queens_local_search_step_tb;
  import qls_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEENS      = QUEENS_DEF;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 190;
  localparam int MOVE_SLACK  = (QUEENS - 1) * (QUEENS + 2) + 10;
  localparam int DIR_N       = 22;
  localparam logic [CFG_ADDR_W-1:0] ACCEPT_ADDR = {CFG_IDX_ACCEPT, 2'b00};

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [COL_W-1:0] column;
    logic [AMT_W-1:0] amount;
    logic [PCT_W-1:0] chance;
  } queen_item_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              accepted;
  } queen_res_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [COL_W-1:0]  column;
    logic [AMT_W-1:0]  amount;
    logic [PCT_W-1:0]  chance;
    logic              fixed;
    logic [COST_W-1:0] cost;
    logic              accepted;
  } dir_row_t;

  // reset board is the main diagonal, so every pair attacks (28 pairs);
  // rows 6..13 load a known solution
  dir_row_t dir_rows [DIR_N] = '{
    '{CMD_LOAD, 3'd0, 3'd0, 7'd0,   1'b1, 5'd28, 1'b0},
    '{CMD_MOVE, 3'd7, 3'd0, 7'd99,  1'b1, 5'd28, 1'b0},
    '{CMD_MOVE, 3'd7, 3'd0, 7'd0,   1'b1, 5'd28, 1'b1},
    '{CMD_MOVE, 3'd4, 3'd7, 7'd127, 1'b0, 5'd0,  1'b0},
    '{CMD_MOVE, 3'd2, 3'd3, 7'd29,  1'b0, 5'd0,  1'b0},
    '{CMD_MOVE, 3'd5, 3'd5, 7'd30,  1'b0, 5'd0,  1'b0},
    '{CMD_LOAD, 3'd0, 3'd0, 7'd0,   1'b0, 5'd0,  1'b0},
    '{CMD_LOAD, 3'd1, 3'd4, 7'd0,   1'b0, 5'd0,  1'b0},
    '{CMD_LOAD, 3'd2, 3'd7, 7'd0,   1'b0, 5'd0,  1'b0},
    '{CMD_LOAD, 3'd3, 3'd5, 7'd0,   1'b0, 5'd0,  1'b0},
    '{CMD_LOAD, 3'd4, 3'd2, 7'd0,   1'b0, 5'd0,  1'b0},
    '{CMD_LOAD, 3'd5, 3'd6, 7'd0,   1'b0, 5'd0,  1'b0},
    '{CMD_LOAD, 3'd6, 3'd1, 7'd0,   1'b0, 5'd0,  1'b0},
    '{CMD_LOAD, 3'd7, 3'd3, 7'd127, 1'b1, 5'd0,  1'b0},
    '{CMD_MOVE, 3'd3, 3'd1, 7'd127, 1'b1, 5'd0,  1'b0},
    '{CMD_MOVE, 3'd6, 3'd7, 7'd100, 1'b1, 5'd0,  1'b0},
    '{CMD_MOVE, 3'd0, 3'd0, 7'd127, 1'b1, 5'd0,  1'b0},
    '{CMD_MOVE, 3'd1, 3'd4, 7'd0,   1'b0, 5'd0,  1'b0},
    '{CMD_LOAD, 3'd7, 3'd7, 7'd127, 1'b0, 5'd0,  1'b0},
    '{CMD_MOVE, 3'd7, 3'd1, 7'd64,  1'b0, 5'd0,  1'b0},
    '{CMD_LOAD, 3'd3, 3'd7, 7'd85,  1'b0, 5'd0,  1'b0},
    '{CMD_MOVE, 3'd0, 3'd7, 7'd1,   1'b0, 5'd0,  1'b0}
  };

  int phase_send   [PHASES] = '{0, 85, 0, 36, 0, 36};
  int phase_recv   [PHASES] = '{0, 0, 85, 36, 0, 36};
  int phase_accept [PHASES] = '{0, 100, 127, -1, -1, 30};

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  qls_in_if  in_ch ();
  qls_out_if out_ch ();

  // board predictor state
  logic [AMT_W-1:0] shadow_rows [QUEENS];
  logic [PCT_W-1:0] shadow_accept;

  queen_res_t pending_results [$];
  queen_res_t want;
  int         mismatches = 0;
  int         send_idle  = 0;
  int         recv_stall = 0;

  queens_local_search_step #(.QUEENS(QUEENS)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic int attack_pairs();
    int total;
    int gap;
    total = 0;
    for (int a = 0; a < QUEENS; a++) begin
      for (int b = a + 1; b < QUEENS; b++) begin
        gap = int'(shadow_rows[a]) - int'(shadow_rows[b]);
        if (gap < 0) gap = -gap;
        if (gap == 0 || gap == b - a) total++;
      end
    end
    return total;
  endfunction

  function automatic queen_res_t step_board(input queen_item_t it);
    queen_res_t       r;
    logic [AMT_W-1:0] old_row;
    int               cost_before;
    int               cost_after;
    int               total;
    r.accepted = 1'b0;
    if (int'(it.column) < QUEENS) begin
      if (it.command == CMD_LOAD) begin
        shadow_rows[it.column] = AMT_W'(int'(it.amount) % QUEENS);
      end else begin
        old_row     = shadow_rows[it.column];
        cost_before = attack_pairs();
        shadow_rows[it.column] = AMT_W'((int'(old_row) + int'(it.amount)) % QUEENS);
        cost_after  = attack_pairs();
        if (cost_after < cost_before || it.chance < shadow_accept) begin
          r.accepted = 1'b1;
        end else begin
          shadow_rows[it.column] = old_row;
        end
      end
    end
    total  = attack_pairs();
    r.cost = (total > int'(COST_MAX)) ? COST_MAX : COST_W'(total);
    return r;
  endfunction

  task automatic send_item(input queen_item_t it, input logic fixed, input queen_res_t fixed_res);
    queen_res_t r;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= it.command;
    in_ch.column  <= it.column;
    in_ch.amount  <= it.amount;
    in_ch.chance  <= it.chance;
    do @(posedge clk); while (!in_ch.ready);
    r = step_board(it);
    if (fixed) r = fixed_res;
    pending_results.push_back(r);
  endtask

  // the sender goes quiet first so the last item is not taken again
  task automatic wait_drained(input int slack);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (slack) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= ACCEPT_ADDR;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_accept_reg();
    logic [CFG_DATA_W-1:0] rd;
    cfg_access(1'b0, '0, rd);
    if (rd !== CFG_DATA_W'(shadow_accept)) begin
      $display("%0t accept_percent readback: expected %0d, actual %0d",
               $time, shadow_accept, rd);
      mismatches++;
    end
  endtask

  task automatic set_accept(input logic [PCT_W-1:0] value);
    logic [CFG_DATA_W-1:0] wdata;
    logic [CFG_DATA_W-1:0] rd;
    // upper bits are junk, only the low 7 bits land in the register
    wdata = $urandom;
    wdata[PCT_W-1:0] = value;
    cfg_access(1'b1, wdata, rd);
    shadow_accept = value;
    check_accept_reg();
  endtask

  // result side: random stalls, compare with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t result with none expected: cost %0d accepted %0b",
                 $time, out_ch.cost, out_ch.accepted);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.cost !== want.cost) begin
          $display("%0t cost: expected %0d, actual %0d", $time, want.cost, out_ch.cost);
          mismatches++;
        end
        if (out_ch.accepted !== want.accepted) begin
          $display("%0t accepted: expected %0b, actual %0b",
                   $time, want.accepted, out_ch.accepted);
          mismatches++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  initial begin
    queen_item_t it;
    queen_res_t  fixed_res;
    int          sent;
    int          pick;
    int          acc;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.command <= CMD_LOAD;
    in_ch.column  <= '0;
    in_ch.amount  <= '0;
    in_ch.chance  <= '0;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    for (int c = 0; c < QUEENS; c++) shadow_rows[c] = AMT_W'(c % QUEENS);
    shadow_accept = ACCEPT_RESET;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_accept_reg();

    for (int i = 0; i < DIR_N; i++) begin
      it        = '{dir_rows[i].command, dir_rows[i].column,
                    dir_rows[i].amount, dir_rows[i].chance};
      fixed_res = '{dir_rows[i].cost, dir_rows[i].accepted};
      send_item(it, dir_rows[i].fixed, fixed_res);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained(MOVE_SLACK);
      acc = (phase_accept[p] < 0) ? $urandom_range(100) : phase_accept[p];
      set_accept(PCT_W'(acc));
      send_idle  = phase_send[p];
      recv_stall = phase_recv[p];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          // fresh random board, then the climb continues from it
          for (int c = 0; c < QUEENS; c++) begin
            it = '{CMD_LOAD, COL_W'(c), AMT_W'($urandom_range(7)),
                   PCT_W'($urandom_range(127))};
            send_item(it, 1'b0, '0);
          end
          sent += QUEENS;
        end else begin
          it.command = (pick < 22) ? CMD_LOAD : CMD_MOVE;
          it.column  = COL_W'($urandom_range((1 << COL_W) - 1));
          it.amount  = AMT_W'($urandom_range((1 << AMT_W) - 1));
          it.chance  = ($urandom_range(9) == 0) ? PCT_W'($urandom_range(127))
                                                : PCT_W'($urandom_range(99));
          send_item(it, 1'b0, '0);
          sent++;
        end
        // let the pipe run dry now and then
        if ($urandom_range(59) == 0) wait_drained(0);
      end
    end

    wait_drained(MOVE_SLACK);
    if (mismatches == 0) begin
      $display("[queens_local_search_step] OK");
    end else begin
      $display("[queens_local_search_step] ERROR");
    end
    $finish;
  end

  initial begin
    #(8_000_000);
    $display("[queens_local_search_step] ERROR");
    $finish;
  end

endmodule
